// ===== rtl/core/adc_board_packet_deframer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ADC board packet deframer
// Clocked concurrent checks with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ADC_BOARD_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define ADC_BOARD_PACKET_DEFRAMER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising edge outside reset.
`define ADCDF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication: cause at one edge, effect at the next.
`define ADCDF_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`else

`define ADCDF_ASSERT(label, clk, rst_n, prop, msg)
`define ADCDF_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg)

`endif

`endif

// ===== rtl/core/adcdf_pkg.sv =====
// ----------------------------------------------------------------------------
// adcdf_pkg
// Shared types and constants of the ADC board packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package adcdf_pkg;

    localparam logic [31:0] GOOD_MARKER = 32'h0003_ffff;
    localparam int          ADC_W       = 14;
    localparam int          ODD_SHIFT   = 16;

    // result queue between parser and output stage
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // packed output data width, rounded up to whole bytes
    localparam int TDATA_W = 80;

    typedef enum logic [1:0] {
        PH_MARKER  = 2'd0,
        PH_HEADER  = 2'd1,
        PH_DATA    = 2'd2,
        PH_TRAILER = 2'd3
    } t_phase;

    typedef struct packed {
        logic [31:0]      event_number;
        logic [ADC_W-1:0] adc_odd;
        logic [ADC_W-1:0] adc_even;
        logic [4:0]       sample_index;
        logic [7:0]       even_channel;
        logic             event_good;
        logic             last_of_event;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== rtl/core/adc_board_packet_deframer_core.sv =====
// ----------------------------------------------------------------------------
// adc_board_packet_deframer_core
// Splits ADC board packets of a readout stream into tagged sample pairs.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one 32-bit readout word per request. Each event is one
//   packet per board: marker, header, one data word per channel pair per
//   sample, trailer. Each data word yields one m_axis request holding both
//   14-bit samples with channel, sample, event number; tuser is the good
//   flag, tlast marks the final data word of the event.
//   i_cfg_we/i_cfg_wdata set the board count; write only while idle.
//   Throughput: one word per cycle while the queue is not full. A data word
//   accepted on s_axis is written into the queue and then loaded into the
//   output register once that is empty or its request leaves.
//   Reset (synchronous, active low) empties the queue, clears the event
//   counter and sets the board count to 1; the parser expects a marker.
//   When m_axis stalls, results pile up in the queue; s_axis_tready drops
//   once the queue holds four results, and all words then wait.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adc_board_packet_deframer_core_assert.svh"

module adc_board_packet_deframer_core
    import adcdf_pkg::*;
#(
    parameter int CHANNELS_PER_BOARD = 64,
    parameter int SAMPLES            = 20,
    parameter int MAX_BOARDS         = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // data_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // from bit 0: even_channel[7:0], sample_index[12:8], adc_even[26:13],
    // adc_odd[40:27], event_number[72:41], zero pad[79:73]
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic             m_axis_tuser,   // event_good
    output logic             m_axis_tlast    // last_of_event
);

    t_q_status q_status;
    logic      q_push;
    logic      q_pop;
    t_result   q_wr_entry;
    t_result   q_rd_entry;

    adcdf_front #(
        .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD),
        .SAMPLES            (SAMPLES),
        .MAX_BOARDS         (MAX_BOARDS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_status    (q_status),
        .o_q_push      (q_push),
        .o_q_entry     (q_wr_entry)
    );

    adcdf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (q_wr_entry),
        .i_pop    (q_pop),
        .o_entry  (q_rd_entry),
        .o_status (q_status)
    );

    adcdf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (q_status),
        .i_q_entry     (q_rd_entry),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // a waiting result reaches an empty output register on the next cycle
    `ADCDF_ASSERT_NEXT(a_queue_drains, i_clk, i_rst_n,
        !q_status.empty && !m_axis_tvalid, m_axis_tvalid,
        "queued result did not reach the output register")

    // the end of an event always falls on the last time sample
    `ADCDF_ASSERT(a_last_on_final_sample, i_clk, i_rst_n,
        !(m_axis_tvalid && m_axis_tlast) || (m_axis_tdata[12:8] == 5'(SAMPLES - 1)),
        "tlast on a sample other than the last one")

    // nothing is taken from the input while the queue is full
    `ADCDF_ASSERT(a_no_push_when_full, i_clk, i_rst_n,
        !(q_push && q_status.full),
        "result pushed into a full queue")

endmodule

`default_nettype wire

// ===== rtl/core/adcdf_front.sv =====
// ----------------------------------------------------------------------------
// adcdf_front
// Packet parser: walks marker/header/data/trailer words and emits one tagged
// result per data word into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module adcdf_front
    import adcdf_pkg::*;
#(
    parameter int CHANNELS_PER_BOARD = 64,
    parameter int SAMPLES            = 20,
    parameter int MAX_BOARDS         = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // data_word
    input  wire t_q_status   i_q_status,
    output logic             o_q_push,
    output t_result          o_q_entry
);

    localparam int PAIRS = (CHANNELS_PER_BOARD + 1) / 2;

    t_phase      r_phase,    n_phase;
    logic [1:0]  r_board,    n_board;
    logic [4:0]  r_pair,     n_pair;
    logic [4:0]  r_sample,   n_sample;
    logic [31:0] r_evt_cnt,  n_evt_cnt;
    logic        r_bad,      n_bad;
    logic [2:0]  r_num_boards;

    logic        accept;
    logic [2:0]  boards_used;
    logic        last_board;
    logic        last_samp;
    logic        last_pair;
    logic [9:0]  chan_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_boards <= 3'd1;
        end else if (i_cfg_we) begin
            r_num_boards <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MARKER;
            r_board   <= '0;
            r_pair    <= '0;
            r_sample  <= '0;
            r_evt_cnt <= '0;
            r_bad     <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_board   <= n_board;
            r_pair    <= n_pair;
            r_sample  <= n_sample;
            r_evt_cnt <= n_evt_cnt;
            r_bad     <= n_bad;
        end
    end

    assign s_axis_tready = !i_q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // zero counts as one board, anything above the maximum saturates
    always_comb begin
        if (r_num_boards == 3'd0) begin
            boards_used = 3'd1;
        end else if (r_num_boards > 3'(MAX_BOARDS)) begin
            boards_used = 3'(MAX_BOARDS);
        end else begin
            boards_used = r_num_boards;
        end
    end

    assign last_board = ({1'b0, r_board} + 3'd1) >= boards_used;
    assign last_samp  = ({1'b0, r_sample} + 6'd1) >= 6'(SAMPLES);
    assign last_pair  = ({1'b0, r_pair} + 6'd1) >= 6'(PAIRS);
    assign chan_full  = 10'(r_board) * 10'(CHANNELS_PER_BOARD) + {4'd0, r_pair, 1'b0};

    always_comb begin
        n_phase   = r_phase;
        n_board   = r_board;
        n_pair    = r_pair;
        n_sample  = r_sample;
        n_evt_cnt = r_evt_cnt;
        n_bad     = r_bad;
        o_q_push  = 1'b0;

        o_q_entry.even_channel  = chan_full[7:0];
        o_q_entry.sample_index  = r_sample;
        o_q_entry.adc_even      = s_axis_tdata[ADC_W-1:0];
        o_q_entry.adc_odd       = s_axis_tdata[ODD_SHIFT +: ADC_W];
        o_q_entry.event_number  = r_evt_cnt;
        o_q_entry.event_good    = !r_bad;
        o_q_entry.last_of_event = last_samp && last_pair && last_board;

        if (accept) begin
            case (r_phase)
                PH_MARKER: begin
                    // only the first board's marker is checked
                    if (r_board == 2'd0) begin
                        if (s_axis_tdata == GOOD_MARKER) begin
                            n_bad     = 1'b0;
                            n_evt_cnt = r_evt_cnt + 32'd1;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    n_phase = PH_HEADER;
                end
                PH_HEADER: begin
                    n_pair   = '0;
                    n_sample = '0;
                    n_phase  = PH_DATA;
                end
                PH_DATA: begin
                    o_q_push = 1'b1;
                    if (last_samp) begin
                        n_sample = '0;
                        if (last_pair) begin
                            n_pair  = '0;
                            n_phase = PH_TRAILER;
                        end else begin
                            n_pair = r_pair + 5'd1;
                        end
                    end else begin
                        n_sample = r_sample + 5'd1;
                    end
                end
                PH_TRAILER: begin
                    n_board = last_board ? 2'd0 : r_board + 2'd1;
                    n_phase = PH_MARKER;
                end
                default: begin
                    n_phase = PH_MARKER;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/adcdf_queue.sv =====
// ----------------------------------------------------------------------------
// adcdf_queue
// Small result FIFO decoupling the parser from the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module adcdf_queue
    import adcdf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_entry,
    input  wire logic    i_pop,
    output t_result      o_entry,
    output t_q_status    o_status
);

    t_result         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_entry        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/adcdf_back.sv =====
// ----------------------------------------------------------------------------
// adcdf_back
// Output register stage: pops the queue and drives the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module adcdf_back
    import adcdf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_q_status  i_q_status,
    input  wire t_result    i_q_entry,
    output logic            o_q_pop,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    // from bit 0: even_channel[7:0], sample_index[12:8], adc_even[26:13],
    // adc_odd[40:27], event_number[72:41], zero pad[79:73]
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic            m_axis_tuser,   // event_good
    output logic            m_axis_tlast    // last_of_event
);

    logic    r_valid;
    t_result r_res;

    // load when the register is empty or its request leaves this cycle
    assign o_q_pop = !i_q_status.empty && (!r_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || m_axis_tready) begin
            r_valid <= !i_q_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= i_q_entry;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'd0, r_res.event_number, r_res.adc_odd, r_res.adc_even,
                            r_res.sample_index, r_res.even_channel};
    assign m_axis_tuser  = r_res.event_good;
    assign m_axis_tlast  = r_res.last_of_event;

endmodule

`default_nettype wire

// ===== bench/adc_board_packet_deframer_core_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_board_packet_deframer_core_checker
// Watches the readout and sample streams of the deframer, tracks the packet
// framing of every accepted word and checks each sample pair request field by
// field against the oldest prediction. Hands its error count and the number of
// predictions still waiting to the bench top.
// ----------------------------------------------------------------------------
module adc_board_packet_deframer_core_checker
    import adcdf_pkg::*;
#(
    parameter int CHANNELS_PER_BOARD = 64,
    parameter int SAMPLES            = 20,
    parameter int MAX_BOARDS         = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_wdata,
    input  wire logic               i_s_tvalid,
    input  wire logic               i_s_tready,
    input  wire logic [31:0]        i_s_tdata,
    input  wire logic               i_m_tvalid,
    input  wire logic               i_m_tready,
    input  wire logic [TDATA_W-1:0] i_m_tdata,
    input  wire logic               i_m_tuser,
    input  wire logic               i_m_tlast,
    output int                      o_pending,
    output int                      o_errors
);

    localparam int PAIRS = (CHANNELS_PER_BOARD + 1) / 2;

    // shadow of the deframer's framing state
    t_phase      frame_phase;
    logic [1:0]  board_idx;
    logic [4:0]  pair_idx;
    logic [4:0]  sample_idx;
    logic [31:0] good_events;
    logic        event_bad;
    logic [2:0]  board_cfg;

    t_result sample_pairs_q[$];
    int      err_cnt = 0;

    initial o_pending = 0;
    assign o_errors = err_cnt;

    function automatic int boards_active();
        int nb;
        nb = int'(board_cfg);
        if (nb < 1) nb = 1;
        if (nb > MAX_BOARDS) nb = MAX_BOARDS;
        return nb;
    endfunction

    // Advances the framing by one readout word; returns 1 when it is a data word.
    function automatic bit deframe_word(input logic [31:0] w, output t_result r);
        bit last_board;
        bit last_samp;
        bit last_pair;
        int ch;
        last_board = (int'(board_idx) + 1) >= boards_active();
        r = '0;
        deframe_word = 1'b0;
        case (frame_phase)
            PH_MARKER: begin
                // only the first board's marker counts
                if (board_idx == 2'd0) begin
                    if (w == GOOD_MARKER) begin
                        event_bad   = 1'b0;
                        good_events = good_events + 32'd1;
                    end else begin
                        event_bad = 1'b1;
                    end
                end
                frame_phase = PH_HEADER;
            end
            PH_HEADER: begin
                pair_idx    = '0;
                sample_idx  = '0;
                frame_phase = PH_DATA;
            end
            PH_DATA: begin
                last_samp = (int'(sample_idx) + 1) >= SAMPLES;
                last_pair = (int'(pair_idx) + 1) >= PAIRS;
                ch = int'(board_idx) * CHANNELS_PER_BOARD + 2 * int'(pair_idx);
                r.even_channel  = ch[7:0];
                r.sample_index  = sample_idx;
                r.adc_even      = w[ADC_W-1:0];
                r.adc_odd       = w[ODD_SHIFT +: ADC_W];
                r.event_number  = good_events;
                r.event_good    = !event_bad;
                r.last_of_event = last_samp && last_pair && last_board;
                if (last_samp) begin
                    sample_idx = '0;
                    if (last_pair) begin
                        pair_idx    = '0;
                        frame_phase = PH_TRAILER;
                    end else begin
                        pair_idx = pair_idx + 5'd1;
                    end
                end else begin
                    sample_idx = sample_idx + 5'd1;
                end
                deframe_word = 1'b1;
            end
            default: begin
                board_idx   = last_board ? 2'd0 : board_idx + 2'd1;
                frame_phase = PH_MARKER;
            end
        endcase
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            frame_phase = PH_MARKER;
            board_idx   = '0;
            pair_idx    = '0;
            sample_idx  = '0;
            good_events = '0;
            event_bad   = 1'b0;
            board_cfg   = 3'd1;
            sample_pairs_q.delete();
        end else begin
            // outputs first: a request never leaves on the edge its word arrives
            if (i_m_tvalid && i_m_tready) begin
                if (sample_pairs_q.size() == 0) begin
                    $display("%0t ns: unexpected request, expected none, got 0x%0h",
                             $time, i_m_tdata);
                    err_cnt++;
                end else begin
                    want = sample_pairs_q.pop_front();
                    check_field("even_channel", want.even_channel, i_m_tdata[7:0]);
                    check_field("sample_index", want.sample_index, i_m_tdata[12:8]);
                    check_field("adc_even", want.adc_even, i_m_tdata[26:13]);
                    check_field("adc_odd", want.adc_odd, i_m_tdata[40:27]);
                    check_field("event_number", want.event_number, i_m_tdata[72:41]);
                    check_field("event_good", want.event_good, i_m_tuser);
                    check_field("last_of_event", want.last_of_event, i_m_tlast);
                end
            end
            // a word taken on the write edge still sees the old board count
            if (i_s_tvalid && i_s_tready) begin
                if (deframe_word(i_s_tdata, pred)) sample_pairs_q.push_back(pred);
            end
            if (i_cfg_we) board_cfg = i_cfg_wdata;
        end
        o_pending <= sample_pairs_q.size();
    end

endmodule

// ===== bench/adc_board_packet_deframer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_board_packet_deframer_core_tb
// Feeds board packets (good and bad first markers, corner data words, a board
// count above the maximum, a count of zero written in mid-event, a short
// trailing event) under random source gaps and sink stalls; the checker
// predicts and compares.
// ----------------------------------------------------------------------------
module adc_board_packet_deframer_core_tb;
    import adcdf_pkg::*;

    localparam int CHANNELS_PER_BOARD = 64;
    localparam int SAMPLES            = 20;
    localparam int MAX_BOARDS         = 4;
    localparam int PAIRS              = (CHANNELS_PER_BOARD + 1) / 2;
    localparam int CYCLE_LIMIT        = 400_000;
    localparam int SETTLE_CYCLES      = 4;
    localparam int N_CORNER           = 10;
    localparam int N_TAIL             = 40;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [2:0]         i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;

    int results_pending;
    int mismatch_count;
    int tx_idle_pct = 12;
    int rx_idle_pct = 62;

    adc_board_packet_deframer_core #(
        .CHANNELS_PER_BOARD(CHANNELS_PER_BOARD),
        .SAMPLES           (SAMPLES),
        .MAX_BOARDS        (MAX_BOARDS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    adc_board_packet_deframer_core_checker #(
        .CHANNELS_PER_BOARD(CHANNELS_PER_BOARD),
        .SAMPLES           (SAMPLES),
        .MAX_BOARDS        (MAX_BOARDS)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .i_m_tlast  (m_axis_tlast),
        .o_pending  (results_pending),
        .o_errors   (mismatch_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    function automatic logic [31:0] corner_word(input int k);
        case (k)
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h0000_3fff;
            3:       return 32'h3fff_0000;
            4:       return 32'h0000_c000;
            5:       return 32'hc000_0000;
            6:       return 32'h3fff_3fff;
            7:       return 32'hc000_c000;
            8:       return 32'h5555_5555;
            default: return 32'haaaa_aaaa;
        endcase
    endfunction

    function automatic logic [31:0] data_word();
        if ($urandom_range(7) == 0) return corner_word($urandom_range(N_CORNER - 1));
        return $urandom;
    endfunction

    function automatic logic [31:0] bad_marker();
        case ($urandom_range(3))
            0:       return GOOD_MARKER ^ (32'd1 << $urandom_range(31));
            1:       return 32'h0000_0000;
            2:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [31:0] w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold the source until every sample pair has left, then let the parser settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_boards(input logic [2:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_board(input bit first, input bit good, input bit corners);
        logic [31:0] marker;
        if (first) marker = good ? GOOD_MARKER : bad_marker();
        else       marker = $urandom_range(1) ? GOOD_MARKER : $urandom; // unchecked
        send_word(marker);
        send_word($urandom);
        for (int k = 0; k < PAIRS * SAMPLES; k++) begin
            send_word((corners && k < N_CORNER) ? corner_word(k) : data_word());
        end
        send_word($urandom);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_boards(3'd7);         // clamps to four boards
        send_board(1'b1, 1'b1, 1'b1);
        wait_drained();

        tx_idle_pct = 62;
        rx_idle_pct = 12;
        write_boards(3'd0);         // acts as one board: the second board closes the event
        send_board(1'b0, 1'b1, 1'b0);
        wait_drained();

        // bad first marker, stream stops a few pairs into the data
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_word(bad_marker());
        send_word($urandom);
        for (int k = 0; k < N_TAIL; k++) send_word(data_word());
        wait_drained();

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/adcdf_pkg.sv
rtl/core/adcdf_front.sv
rtl/core/adcdf_queue.sv
rtl/core/adcdf_back.sv
rtl/core/adc_board_packet_deframer_core.sv
bench/adc_board_packet_deframer_core_checker.sv
bench/adc_board_packet_deframer_core_tb.sv
